[rtl/lag_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lag_pkg: shared definitions of the Life grid engine
// Field widths, item kinds, register indexes, pixel levels and the
// control bundle that the top level hands to every row cell.
// ----------------------------------------------------------------------------
package lag_pkg;

  // Fixed field widths
  localparam int KIND_W    = 2;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int LEVEL_W   = 8;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 8;

  // Default grid limits
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  // Size register value after reset
  localparam logic [CFG_W-1:0] RESET_SIZE = 7'd64;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD = 2'd0,
    KIND_STEP = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 8'd1;

  // Pixel levels
  localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 8'hFF;
  localparam logic [LEVEL_W-1:0] LEVEL_ALIVE = 8'h00;

  // B3/S23 neighbor counts
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // Per-transaction control seen by every row cell
  typedef struct packed {
    logic             load;
    logic             load_val;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } cell_ctl_t;

endpackage

[rtl/lag_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lag_if: channel interfaces of the Life grid engine
// Input item channel, result channel and register write channel, each a
// valid/ready pair with its payload.
// ----------------------------------------------------------------------------

// Input item channel
interface lag_in_if;
  logic                          valid;
  logic                          ready;
  logic [lag_pkg::KIND_W-1:0]    kind;
  logic [lag_pkg::ROW_W-1:0]     row;
  logic [lag_pkg::COL_W-1:0]     column;
  logic [lag_pkg::LEVEL_W-1:0]   blue_level;
  logic [lag_pkg::LEVEL_W-1:0]   green_level;
  logic [lag_pkg::LEVEL_W-1:0]   red_level;

  modport source (output valid, kind, row, column, blue_level, green_level, red_level,
                  input ready);
  modport sink   (input valid, kind, row, column, blue_level, green_level, red_level,
                  output ready);
endinterface

// Result channel
interface lag_out_if;
  logic                          valid;
  logic                          ready;
  logic                          alive;
  logic [lag_pkg::LEVEL_W-1:0]   pixel_level;

  modport source (output valid, alive, pixel_level, input ready);
  modport sink   (input valid, alive, pixel_level, output ready);
endinterface

// Register write channel
interface lag_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lag_pkg::CFG_IDX_W-1:0] addr;
  logic [lag_pkg::CFG_W-1:0]     data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

[rtl/lag_row_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lag_row_cell: one grid row of the Life engine
// Holds one row of cells, writes a single cell on a load, returns the
// addressed cell on a read and takes the row of its neighbor in a step.
// ----------------------------------------------------------------------------
module lag_row_cell #(
  parameter int MAX_WIDTH = lag_pkg::DEF_MAX_WIDTH,
  parameter int IDX       = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift_en,
  input  logic [MAX_WIDTH-1:0]  shift_in,
  input  lag_pkg::cell_ctl_t    ctl,
  output logic [MAX_WIDTH-1:0]  row_q,
  output logic                  rd_bit
);

  localparam int CIW = $clog2(MAX_WIDTH);

  logic [MAX_WIDTH-1:0] row_r;
  logic [MAX_WIDTH-1:0] row_nxt;
  logic [CIW-1:0]       col_idx;
  logic                 hit;

  assign col_idx = CIW'(ctl.col);
  assign hit     = (int'(ctl.row) == IDX);

  // Take the neighbor's row in a step, else write the addressed cell
  always_comb begin
    row_nxt = row_r;
    if (shift_en) begin
      row_nxt = shift_in;
    end else if (ctl.load && hit) begin
      row_nxt[col_idx] = ctl.load_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row_q  = row_r;
  assign rd_bit = hit & row_r[col_idx];

endmodule

[rtl/lag_row_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lag_row_eval: next-generation row of the Life engine
// Applies B3/S23 to one row from the rows above and below, wrapping the
// columns at the used width. Columns past the used width keep their value.
// ----------------------------------------------------------------------------
module lag_row_eval #(
  parameter int MAX_WIDTH = lag_pkg::DEF_MAX_WIDTH
) (
  input  logic [MAX_WIDTH-1:0]               up_row,
  input  logic [MAX_WIDTH-1:0]               mid_row,
  input  logic [MAX_WIDTH-1:0]               dn_row,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     w_used,
  output logic [MAX_WIDTH-1:0]               new_row
);

  localparam int CW  = $clog2(MAX_WIDTH+1);
  localparam int CIW = $clog2(MAX_WIDTH);

  function automatic logic life_next(input logic [7:0] nb, input logic self_alive);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, nb[i]};
    end
    if (self_alive) begin
      return (n == lag_pkg::SURVIVE_COUNT) || (n == lag_pkg::BIRTH_COUNT);
    end
    return (n == lag_pkg::BIRTH_COUNT);
  endfunction

  logic [CIW-1:0] last_idx;
  logic           up_last;
  logic           mid_last;
  logic           dn_last;

  // Pick the wrap column on the left edge
  assign last_idx = CIW'(w_used - CW'(1));
  assign up_last  = up_row[last_idx];
  assign mid_last = mid_row[last_idx];
  assign dn_last  = dn_row[last_idx];

  for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_col
    logic       up_l, mid_l, dn_l;
    logic       up_rt, mid_rt, dn_rt;
    logic       at_edge;
    logic [7:0] nb;

    if (c == 0) begin : g_left_wrap
      assign up_l  = up_last;
      assign mid_l = mid_last;
      assign dn_l  = dn_last;
    end else begin : g_left
      assign up_l  = up_row[c-1];
      assign mid_l = mid_row[c-1];
      assign dn_l  = dn_row[c-1];
    end

    if (c == MAX_WIDTH-1) begin : g_right_wrap
      assign up_rt  = up_row[0];
      assign mid_rt = mid_row[0];
      assign dn_rt  = dn_row[0];
      assign at_edge = 1'b1;
    end else begin : g_right
      assign at_edge = (int'(w_used) - 1 == c);
      assign up_rt  = at_edge ? up_row[0]  : up_row[c+1];
      assign mid_rt = at_edge ? mid_row[0] : mid_row[c+1];
      assign dn_rt  = at_edge ? dn_row[0]  : dn_row[c+1];
    end

    assign nb = {up_l, up_row[c], up_rt, mid_l, mid_rt, dn_l, dn_row[c], dn_rt};

    // Hold columns outside the used width
    assign new_row[c] = (c < int'(w_used)) ? life_next(nb, mid_row[c]) : mid_row[c];
  end

endmodule

[rtl/life_automaton_toroidal_grid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_automaton_toroidal_grid: Conway Life engine on a wrap-around grid
// Top level: item decode, size registers, step sequencer, row cell chain,
// row evaluator and the result register with its skid stage.
// ----------------------------------------------------------------------------
// A load or a read is taken in a single handshake; a read's result is
// registered in the output register, or in the skid stage while the output
// is held, and the skid stage lets a further item be taken while that result
// waits. A step is accepted in the idle state and then runs over the used rows:
// the rows circulate through a chain of row cells and pass the single row
// evaluator one per cycle, so that at the end of the step every cell again
// holds its own row, now one generation on. No item is taken while a step runs.
// Reset clears the whole grid at once and sets both size registers to 64;
// register writes are taken in every cycle.
// ----------------------------------------------------------------------------
module life_automaton_toroidal_grid #(
  parameter int MAX_WIDTH  = lag_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lag_pkg::DEF_MAX_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  lag_cfg_if.sink    cfg_ch,
  lag_in_if.sink     in_ch,
  lag_out_if.source  out_ch
);

  localparam int CW   = $clog2(MAX_WIDTH+1);
  localparam int HW   = $clog2(MAX_HEIGHT+1);
  localparam int RIW  = $clog2(MAX_HEIGHT);
  localparam int WCMP = (CW > lag_pkg::CFG_W) ? CW : lag_pkg::CFG_W;
  localparam int HCMP = (HW > lag_pkg::CFG_W) ? HW : lag_pkg::CFG_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_STEP = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [lag_pkg::CFG_W-1:0] width_r;
  logic [lag_pkg::CFG_W-1:0] height_r;
  logic [CW-1:0]             w_used;
  logic [HW-1:0]             h_used;
  logic [WCMP-1:0]           w_ext;
  logic [HCMP-1:0]           h_ext;

  logic                      in_acc;
  logic                      in_grid;
  logic                      step_acc;
  logic                      read_acc;
  logic                      pix_alive;
  lag_pkg::cell_ctl_t        ctl;

  logic [MAX_WIDTH-1:0]      row_q [MAX_HEIGHT];
  logic [MAX_HEIGHT-1:0]     rd_bits;
  logic [MAX_WIDTH-1:0]      tail_row;
  logic [MAX_WIDTH-1:0]      dn_row;
  logic [MAX_WIDTH-1:0]      new_row;
  logic [MAX_WIDTH-1:0]      prev_r, prev_nxt;
  logic [MAX_WIDTH-1:0]      first_r, first_nxt;
  logic [RIW-1:0]            cnt_r, cnt_nxt;
  logic [RIW-1:0]            last_row;
  logic                      stepping;

  logic                      rd_alive;
  logic                      out_v_r, out_v_nxt;
  logic                      out_alive_r, out_alive_nxt;
  logic                      skid_v_r, skid_v_nxt;
  logic                      skid_alive_r, skid_alive_nxt;
  logic                      slot_free;

  // Register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lag_pkg::RESET_SIZE;
      height_r <= lag_pkg::RESET_SIZE;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.addr == lag_pkg::REG_GRID_WIDTH) begin
        width_r <= cfg_ch.data;
      end else if (cfg_ch.addr == lag_pkg::REG_GRID_HEIGHT) begin
        height_r <= cfg_ch.data;
      end
    end
  end

  // Clamp the size registers to 1..MAX
  assign w_ext = WCMP'(width_r);
  assign h_ext = HCMP'(height_r);

  always_comb begin
    if (width_r == '0) begin
      w_used = CW'(1);
    end else if (w_ext > WCMP'(MAX_WIDTH)) begin
      w_used = CW'(MAX_WIDTH);
    end else begin
      w_used = CW'(w_ext);
    end
    if (height_r == '0) begin
      h_used = HW'(1);
    end else if (h_ext > HCMP'(MAX_HEIGHT)) begin
      h_used = HW'(MAX_HEIGHT);
    end else begin
      h_used = HW'(h_ext);
    end
  end

  // Decode the input transaction
  assign in_ch.ready = (state_r == ST_IDLE) && !skid_v_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_grid     = (int'(in_ch.row) < int'(h_used)) && (int'(in_ch.column) < int'(w_used));
  assign step_acc    = in_acc && (in_ch.kind == lag_pkg::KIND_STEP);
  assign read_acc    = in_acc && (in_ch.kind == lag_pkg::KIND_READ);
  assign pix_alive   = (in_ch.blue_level  != lag_pkg::LEVEL_FULL) &&
                       (in_ch.green_level != lag_pkg::LEVEL_FULL) &&
                       (in_ch.red_level   != lag_pkg::LEVEL_FULL);

  assign ctl.load     = in_acc && (in_ch.kind == lag_pkg::KIND_LOAD) && in_grid;
  assign ctl.load_val = pix_alive;
  assign ctl.row      = in_ch.row;
  assign ctl.col      = in_ch.column;

  assign stepping = (state_r == ST_STEP);
  assign last_row = RIW'(h_used - HW'(1));

  // Row cell chain: rows below the used height shift toward cell 0,
  // the evaluated row enters at the last used cell
  for (genvar i = 0; i < MAX_HEIGHT; i++) begin : g_cell
    logic                 sh_en;
    logic [MAX_WIDTH-1:0] sh_in;

    assign sh_en = stepping && (i < int'(h_used));

    if (i == MAX_HEIGHT-1) begin : g_end
      assign sh_in = new_row;
    end else begin : g_mid
      assign sh_in = (i == int'(h_used) - 1) ? new_row : row_q[i+1];
    end

    lag_row_cell #(
      .MAX_WIDTH (MAX_WIDTH),
      .IDX       (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (sh_en),
      .shift_in (sh_in),
      .ctl      (ctl),
      .row_q    (row_q[i]),
      .rd_bit   (rd_bits[i])
    );
  end

  // Gather the last used row for the wrap above row 0
  always_comb begin
    tail_row = '0;
    for (int i = 0; i < MAX_HEIGHT; i++) begin
      if (i == int'(h_used) - 1) begin
        tail_row = tail_row | row_q[i];
      end
    end
  end

  // Below the last used row wraps to the saved copy of row 0
  assign dn_row = (cnt_r == last_row) ? first_r : row_q[1];

  lag_row_eval #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_eval (
    .up_row  (prev_r),
    .mid_row (row_q[0]),
    .dn_row  (dn_row),
    .w_used  (w_used),
    .new_row (new_row)
  );

  // Step sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    prev_nxt  = prev_r;
    first_nxt = first_r;
    unique case (state_r)
      ST_IDLE: begin
        if (step_acc) begin
          state_nxt = ST_STEP;
          cnt_nxt   = '0;
          prev_nxt  = tail_row;
          first_nxt = row_q[0];
        end
      end
      ST_STEP: begin
        prev_nxt = row_q[0];
        cnt_nxt  = cnt_r + RIW'(1);
        if (cnt_r == last_row) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r  <= prev_nxt;
    first_r <= first_nxt;
  end

  // Read result and output register with skid stage
  assign rd_alive  = in_grid && (|rd_bits);
  assign slot_free = !out_v_r || out_ch.ready;

  always_comb begin
    out_v_nxt      = out_v_r;
    out_alive_nxt  = out_alive_r;
    skid_v_nxt     = skid_v_r;
    skid_alive_nxt = skid_alive_r;
    if (slot_free) begin
      out_v_nxt     = skid_v_r || read_acc;
      out_alive_nxt = skid_v_r ? skid_alive_r : rd_alive;
      skid_v_nxt    = 1'b0;
    end else if (read_acc) begin
      skid_v_nxt     = 1'b1;
      skid_alive_nxt = rd_alive;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_alive_r  <= out_alive_nxt;
    skid_alive_r <= skid_alive_nxt;
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.alive       = out_alive_r;
  assign out_ch.pixel_level = out_alive_r ? lag_pkg::LEVEL_ALIVE : lag_pkg::LEVEL_FULL;

endmodule

[verif/tb_life_automaton_toroidal_grid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_life_automaton_toroidal_grid: self-checking bench of the Life engine
// Loads cells from pixels, advances generations and reads cells back under
// a sequence of grid sizes, tiny, wrapped, clamped and full. A scoreboard
// keeps its own copy of the grid and queues the cell report of every read,
// so that each result transaction is compared with the oldest one.
// ----------------------------------------------------------------------------
module tb_life_automaton_toroidal_grid;

  localparam int GRID_W       = lag_pkg::DEF_MAX_WIDTH;
  localparam int GRID_H       = lag_pkg::DEF_MAX_HEIGHT;
  localparam int DRAIN_CYCLES = GRID_H + 16;
  localparam int STALL_LIMIT  = 4000;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASES       = 17;
  localparam int PHASE_ITEMS  = 100;
  localparam int SIZE_BITS    = lag_pkg::CFG_W;

  typedef struct packed {
    lag_pkg::kind_t              kind;
    logic [lag_pkg::ROW_W-1:0]   row;
    logic [lag_pkg::COL_W-1:0]   column;
    logic [lag_pkg::LEVEL_W-1:0] blue;
    logic [lag_pkg::LEVEL_W-1:0] green;
    logic [lag_pkg::LEVEL_W-1:0] red;
  } life_item_t;

  typedef struct packed {
    logic                        alive;
    logic [lag_pkg::LEVEL_W-1:0] level;
  } cell_report_t;

  // Grid tracker: own copy of the cells and size registers, queue of reads
  class life_grid_tracker;
    bit                        cells [GRID_H][GRID_W];
    logic [lag_pkg::CFG_W-1:0] width_reg;
    logic [lag_pkg::CFG_W-1:0] height_reg;
    cell_report_t              expected_reads[$];
    int                        mismatches;
    int                        checked;
    int                        loads;
    int                        steps;
    int                        reads;
    int                        ignored;

    function void clear();
      foreach (cells[r, c]) cells[r][c] = 1'b0;
      width_reg  = lag_pkg::RESET_SIZE;
      height_reg = lag_pkg::RESET_SIZE;
    endfunction

    // Zero acts as one, oversize clamps to the maximum
    function int used_extent(logic [lag_pkg::CFG_W-1:0] size, int limit);
      if (size == 0) return 1;
      return (size > limit) ? limit : int'(size);
    endfunction

    function void write_reg(logic [lag_pkg::CFG_IDX_W-1:0] idx,
                            logic [lag_pkg::CFG_W-1:0] data);
      if (idx == lag_pkg::REG_GRID_WIDTH) width_reg = data;
      else if (idx == lag_pkg::REG_GRID_HEIGHT) height_reg = data;
    endfunction

    // B3/S23 over the used region; all eight wrapped positions are counted
    function void advance_generation();
      bit nxt [GRID_H][GRID_W];
      int w, h, up, dn, lf, rt, n;
      w = used_extent(width_reg, GRID_W);
      h = used_extent(height_reg, GRID_H);
      nxt = cells;
      for (int r = 0; r < h; r++) begin
        up = (r == 0) ? h - 1 : r - 1;
        dn = (r == h - 1) ? 0 : r + 1;
        for (int c = 0; c < w; c++) begin
          lf = (c == 0) ? w - 1 : c - 1;
          rt = (c == w - 1) ? 0 : c + 1;
          n = cells[up][lf] + cells[up][c] + cells[up][rt] + cells[r][lf] + cells[r][rt]
            + cells[dn][lf] + cells[dn][c] + cells[dn][rt];
          if (cells[r][c])
            nxt[r][c] = (n == lag_pkg::SURVIVE_COUNT || n == lag_pkg::BIRTH_COUNT);
          else nxt[r][c] = (n == lag_pkg::BIRTH_COUNT);
        end
      end
      cells = nxt;
    endfunction

    // Apply one accepted input transaction
    function void apply_item(life_item_t it);
      int w, h;
      bit on_grid, state;
      w = used_extent(width_reg, GRID_W);
      h = used_extent(height_reg, GRID_H);
      on_grid = (it.row < h) && (it.column < w);
      case (it.kind)
        lag_pkg::KIND_LOAD: begin
          loads++;
          if (on_grid)
            cells[it.row][it.column] = (it.blue != lag_pkg::LEVEL_FULL)
                                       && (it.green != lag_pkg::LEVEL_FULL)
                                       && (it.red != lag_pkg::LEVEL_FULL);
        end
        lag_pkg::KIND_STEP: begin
          steps++;
          advance_generation();
        end
        lag_pkg::KIND_READ: begin
          reads++;
          state = on_grid && cells[it.row][it.column];
          expected_reads.push_back('{alive: state,
                                     level: state ? lag_pkg::LEVEL_ALIVE
                                                  : lag_pkg::LEVEL_FULL});
        end
        default: ignored++;
      endcase
    endfunction

    function void flag(string what, int want, int got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    // Compare one result transaction with the oldest pending read
    function void compare_read(logic alive, logic [lag_pkg::LEVEL_W-1:0] level);
      cell_report_t want;
      if (expected_reads.size() == 0) begin
        flag("unrequested result (alive)", -1, alive);
        return;
      end
      want = expected_reads.pop_front();
      checked++;
      if (alive !== want.alive) flag("alive", want.alive, alive);
      if (level !== want.level) flag("pixel_level", want.level, level);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   no_gaps;
  int   quiet_cycles;
  int   size_settings;
  life_grid_tracker tracker;

  int size_plan [10][2] = '{'{64, 64}, '{1, 1}, '{0, 0}, '{2, 1}, '{1, 2}, '{3, 3},
                            '{127, 127}, '{127, 0}, '{0, 127}, '{8, 5}};

  lag_cfg_if cfg_ch ();
  lag_in_if  in_ch ();
  lag_out_if out_ch ();

  life_automaton_toroidal_grid DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stall the result channel about one cycle in ten
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 10);
  end

  // Check every result transaction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.compare_read(out_ch.alive, out_ch.pixel_level);
  end

  // Abort when no channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic life_item_t cell_item(lag_pkg::kind_t kind, int row, int col,
                                           int b, int g, int r);
    life_item_t it;
    it.kind   = kind;
    it.row    = row[lag_pkg::ROW_W-1:0];
    it.column = col[lag_pkg::COL_W-1:0];
    it.blue   = b[lag_pkg::LEVEL_W-1:0];
    it.green  = g[lag_pkg::LEVEL_W-1:0];
    it.red    = r[lag_pkg::LEVEL_W-1:0];
    return it;
  endfunction

  function automatic life_item_t any_item(lag_pkg::kind_t kind, int row, int col);
    return cell_item(kind, row, col, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255));
  endfunction

  // Random pixel; force one channel to full often enough to load dead cells
  function automatic life_item_t pixel_load(int row, int col);
    life_item_t it;
    it = any_item(lag_pkg::KIND_LOAD, row, col);
    if ($urandom_range(0, 99) < 45) begin
      case ($urandom_range(0, 2))
        0:       it.blue  = lag_pkg::LEVEL_FULL;
        1:       it.green = lag_pkg::LEVEL_FULL;
        default: it.red   = lag_pkg::LEVEL_FULL;
      endcase
    end
    return it;
  endfunction

  // Drive one input transaction, with an occasional gap ahead of it
  task automatic send_item(input life_item_t it);
    int gap;
    gap = 0;
    if (!no_gaps) while ($urandom_range(0, 99) < 10) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= it.kind;
    in_ch.row         <= it.row;
    in_ch.column      <= it.column;
    in_ch.blue_level  <= it.blue;
    in_ch.green_level <= it.green;
    in_ch.red_level   <= it.red;
    do @(posedge clk); while (!in_ch.ready);
    tracker.apply_item(it);
  endtask

  // Drop valid, wait for all reads, then let a full step finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.expected_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both size registers back to back
  task automatic set_size(input logic [lag_pkg::CFG_W-1:0] w_reg,
                          input logic [lag_pkg::CFG_W-1:0] h_reg);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= lag_pkg::REG_GRID_WIDTH;
    cfg_ch.data  <= w_reg;
    do @(posedge clk); while (!cfg_ch.ready);
    tracker.write_reg(lag_pkg::REG_GRID_WIDTH, w_reg);
    cfg_ch.addr  <= lag_pkg::REG_GRID_HEIGHT;
    cfg_ch.data  <= h_reg;
    do @(posedge clk); while (!cfg_ch.ready);
    tracker.write_reg(lag_pkg::REG_GRID_HEIGHT, h_reg);
    cfg_ch.valid <= 1'b0;
    size_settings++;
  endtask

  // Seed a pattern, then mix steps, reads, more loads and some noise
  task automatic run_phase(input logic [lag_pkg::CFG_W-1:0] w_reg,
                           input logic [lag_pkg::CFG_W-1:0] h_reg,
                           input int budget);
    int w, h, seeds, sent, roll;
    life_item_t it;
    set_size(w_reg, h_reg);
    w = tracker.used_extent(w_reg, GRID_W);
    h = tracker.used_extent(h_reg, GRID_H);
    seeds = (w * h < 40) ? w * h : 40;
    sent = 0;
    repeat (seeds) begin
      send_item(pixel_load($urandom_range(0, h - 1), $urandom_range(0, w - 1)));
      sent++;
    end
    while (sent < budget) begin
      roll = $urandom_range(0, 99);
      if (roll < 10)
        it = any_item(lag_pkg::kind_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                      $urandom_range(0, 63));
      else if (roll < 25)
        it = any_item(lag_pkg::KIND_STEP, $urandom_range(0, 63), $urandom_range(0, 63));
      else if (roll < 70)
        it = any_item(lag_pkg::KIND_READ, $urandom_range(0, h - 1),
                      $urandom_range(0, w - 1));
      else
        it = pixel_load($urandom_range(0, h - 1), $urandom_range(0, w - 1));
      send_item(it);
      // Unused kinds and loads off the grid change nothing
      if (it.kind != lag_pkg::KIND_NONE &&
          !(it.kind == lag_pkg::KIND_LOAD && (it.row >= h || it.column >= w)))
        sent++;
    end
  endtask

  initial begin
    logic [lag_pkg::CFG_W-1:0] wv, hv;
    tracker = new;
    tracker.clear();
    rst_n              <= 1'b0;
    no_gaps            <= 1'b0;
    size_settings      = 0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.addr        <= lag_pkg::REG_GRID_WIDTH;
    cfg_ch.data        <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.kind         <= lag_pkg::KIND_LOAD;
    in_ch.row          <= '0;
    in_ch.column       <= '0;
    in_ch.blue_level   <= '0;
    in_ch.green_level  <= '0;
    in_ch.red_level    <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset sizes: cleared grid, channel extremes, blinker wrapping a corner
    send_item(cell_item(lag_pkg::KIND_READ, 0, 0, 0, 0, 0));
    send_item(cell_item(lag_pkg::KIND_LOAD, 0, 63, 0, 0, 0));
    send_item(cell_item(lag_pkg::KIND_LOAD, 0, 0, 254, 254, 254));
    send_item(cell_item(lag_pkg::KIND_LOAD, 0, 1, 0, 128, 1));
    send_item(cell_item(lag_pkg::KIND_LOAD, 63, 63, 255, 255, 255));
    send_item(cell_item(lag_pkg::KIND_LOAD, 40, 40, 0, 0, 0));
    send_item(cell_item(lag_pkg::KIND_LOAD, 40, 40, 255, 0, 0));
    send_item(cell_item(lag_pkg::KIND_READ, 40, 40, 255, 255, 255));
    send_item(cell_item(lag_pkg::KIND_NONE, 5, 5, 0, 0, 0));
    send_item(cell_item(lag_pkg::KIND_READ, 5, 5, 0, 0, 0));
    send_item(cell_item(lag_pkg::KIND_STEP, 63, 63, 255, 255, 255));
    send_item(cell_item(lag_pkg::KIND_READ, 63, 0, 0, 0, 0));
    send_item(cell_item(lag_pkg::KIND_READ, 0, 0, 0, 0, 0));
    send_item(cell_item(lag_pkg::KIND_READ, 1, 0, 0, 0, 0));
    send_item(cell_item(lag_pkg::KIND_READ, 0, 1, 0, 0, 0));
    settle();

    // Zero width acts as one column, oversize height clamps to the maximum
    set_size(7'd0, 7'd127);
    send_item(cell_item(lag_pkg::KIND_LOAD, 10, 0, 7, 8, 9));
    send_item(cell_item(lag_pkg::KIND_LOAD, 10, 1, 0, 0, 0));
    send_item(cell_item(lag_pkg::KIND_READ, 10, 1, 0, 0, 0));
    send_item(cell_item(lag_pkg::KIND_STEP, 0, 0, 0, 0, 0));
    send_item(cell_item(lag_pkg::KIND_READ, 10, 0, 0, 0, 0));
    settle();

    // Two by two grid: neighbors coincide and count more than once
    set_size(7'd2, 7'd2);
    send_item(cell_item(lag_pkg::KIND_LOAD, 0, 0, 0, 0, 0));
    send_item(cell_item(lag_pkg::KIND_LOAD, 1, 1, 0, 0, 0));
    send_item(cell_item(lag_pkg::KIND_STEP, 0, 0, 0, 0, 0));
    send_item(cell_item(lag_pkg::KIND_READ, 0, 0, 0, 0, 0));
    send_item(cell_item(lag_pkg::KIND_READ, 1, 1, 0, 0, 0));
    send_item(cell_item(lag_pkg::KIND_READ, 2, 2, 0, 0, 0));
    settle();

    // Random phases, each under its own grid size
    for (int p = 0; p < PHASES; p++) begin
      if (p < 10) begin
        wv = size_plan[p][0][SIZE_BITS-1:0];
        hv = size_plan[p][1][SIZE_BITS-1:0];
      end else if ($urandom_range(0, 99) < 70) begin
        wv = SIZE_BITS'($urandom_range(1, 12));
        hv = SIZE_BITS'($urandom_range(1, 12));
      end else begin
        wv = SIZE_BITS'($urandom_range(0, 127));
        hv = SIZE_BITS'($urandom_range(0, 127));
      end
      no_gaps <= (p == 4);
      run_phase(wv, hv, PHASE_ITEMS);
      settle();
    end

    $display("Covered %0d loads, %0d steps, %0d reads (%0d checked), %0d ignored items",
             tracker.loads, tracker.steps, tracker.reads, tracker.checked, tracker.ignored);
    $display("across %0d grid size settings; %0d mismatches", size_settings,
             tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.expected_reads.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/lag_pkg.sv
rtl/lag_if.sv
rtl/lag_row_cell.sv
rtl/lag_row_eval.sv
rtl/life_automaton_toroidal_grid.sv
verif/tb_life_automaton_toroidal_grid.sv
